[src/variable_width_fixed_point_alu_defines.svh]
// Assertion macros used by the checker file.
`ifndef VARIABLE_WIDTH_FIXED_POINT_ALU_DEFINES_SVH
`define VARIABLE_WIDTH_FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define VWFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vwfp assertion failed");

// Consequent checked a fixed number of cycles after the antecedent.
`define VWFP_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("vwfp latency assertion failed");

`endif

[src/vwfp_pkg.sv]
package vwfp_pkg;

    localparam int VALUE_W = 64;
    localparam int WIDTH_W = 7;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_SUB    = 3'd1;
    localparam logic [2:0] KIND_MUL    = 3'd2;
    localparam logic [2:0] KIND_SHL    = 3'd3;
    localparam logic [2:0] KIND_SHR    = 3'd4;
    localparam logic [2:0] KIND_RESIZE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLAMPED = 2'd1;
    localparam logic [1:0] ST_UNDER   = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [VALUE_W-1:0] a_value;
        logic [WIDTH_W-1:0] a_width;
        logic [VALUE_W-1:0] b_value;
        logic [WIDTH_W-1:0] b_width;
        logic [WIDTH_W-1:0] amount;
    } op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic [WIDTH_W-1:0] result_width;
        logic [1:0]         status;
    } res_t;

    // Decode stage output
    typedef struct packed {
        logic [2:0]         kind;
        logic [VALUE_W-1:0] a_m;     // a masked to its width
        logic [VALUE_W-1:0] sa;      // a sign-extended to 64 bits
        logic [VALUE_W-1:0] sb;      // b sign-extended to 64 bits
        logic [WIDTH_W-1:0] amount;
        logic [WIDTH_W-1:0] w;
        logic [1:0]         st;
    } s1_t;

    // Execute stage output
    typedef struct packed {
        logic               is_mul;
        logic [VALUE_W-1:0] val;
        logic [VALUE_W-1:0] p_ll;
        logic [31:0]        p_lh;
        logic [31:0]        p_hl;
        logic [VALUE_W-1:0] mask;
        logic [WIDTH_W-1:0] w;
        logic [1:0]         st;
    } s2_t;

    function automatic logic [VALUE_W-1:0] low_mask(input logic [WIDTH_W-1:0] n);
        logic [VALUE_W-1:0] m;
        if (n >= WIDTH_W'(VALUE_W))
            m = '1;
        else
            m = (VALUE_W'(1) << n) - VALUE_W'(1);
        return m;
    endfunction

endpackage

[src/vwfp_decode.sv]
module vwfp_decode
    import vwfp_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  op_t  op,
    output logic out_valid,
    output s1_t  s1
);

    localparam logic [WIDTH_W-1:0] MAXW = WIDTH_W'(MAX_WIDTH);

    logic               valid_reg;
    s1_t                s1_reg;
    s1_t                s1_next;
    logic [WIDTH_W-1:0] wa;
    logic [WIDTH_W-1:0] wb;
    logic [WIDTH_W-1:0] wa_m1;
    logic [WIDTH_W-1:0] wb_m1;
    logic [VALUE_W-1:0] mask_a;
    logic [VALUE_W-1:0] mask_b;
    logic [VALUE_W-1:0] b_m;
    logic [WIDTH_W:0]   sum_mul;
    logic [WIDTH_W:0]   sum_shl;

    always_comb
    begin
        if (op.a_width == '0)
            wa = WIDTH_W'(1);
        else if (op.a_width > MAXW)
            wa = MAXW;
        else
            wa = op.a_width;
        if (op.b_width == '0)
            wb = WIDTH_W'(1);
        else if (op.b_width > MAXW)
            wb = MAXW;
        else
            wb = op.b_width;
    end

    assign wa_m1   = wa - WIDTH_W'(1);
    assign wb_m1   = wb - WIDTH_W'(1);
    assign mask_a  = low_mask(wa);
    assign mask_b  = low_mask(wb);
    assign b_m     = op.b_value & mask_b;
    assign sum_mul = {1'b0, wa} + {1'b0, wb};
    assign sum_shl = {1'b0, wa} + {1'b0, op.amount};

    always_comb
    begin
        s1_next.kind   = op.kind;
        s1_next.amount = op.amount;
        s1_next.a_m    = op.a_value & mask_a;
        s1_next.sa     = op.a_value[wa_m1[5:0]] ? (s1_next.a_m | ~mask_a) : s1_next.a_m;
        s1_next.sb     = op.b_value[wb_m1[5:0]] ? (b_m | ~mask_b) : b_m;
        s1_next.w      = wa;
        s1_next.st     = ST_OK;
        unique case (op.kind)
            KIND_ADD, KIND_SUB:
            begin
                s1_next.w = (wa > wb) ? wa : wb;
            end
            KIND_MUL:
            begin
                if (sum_mul > {1'b0, MAXW})
                begin
                    s1_next.w  = MAXW;
                    s1_next.st = ST_CLAMPED;
                end
                else
                    s1_next.w = sum_mul[WIDTH_W-1:0];
            end
            KIND_SHL:
            begin
                if (sum_shl > {1'b0, MAXW})
                begin
                    s1_next.w  = MAXW;
                    s1_next.st = ST_CLAMPED;
                end
                else
                    s1_next.w = sum_shl[WIDTH_W-1:0];
            end
            KIND_SHR:
            begin
                if (op.amount >= wa)
                begin
                    s1_next.w  = WIDTH_W'(1);
                    s1_next.st = ST_UNDER;
                end
                else
                    s1_next.w = wa - op.amount;
            end
            KIND_RESIZE:
            begin
                if (op.amount == '0)
                begin
                    s1_next.w  = WIDTH_W'(1);
                    s1_next.st = ST_UNDER;
                end
                else if (op.amount > MAXW)
                begin
                    s1_next.w  = MAXW;
                    s1_next.st = ST_CLAMPED;
                end
                else
                    s1_next.w = op.amount;
            end
            default:
            begin
                s1_next.w = wa;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign out_valid = valid_reg;
    assign s1        = s1_reg;

endmodule

[src/vwfp_execute.sv]
module vwfp_execute
    import vwfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  s1_t  s1,
    output logic out_valid,
    output s2_t  s2
);

    logic  valid_reg;
    s2_t   s2_reg;
    s2_t   s2_next;
    logic  [63:0] prod_ll;
    logic  [31:0] prod_lh;
    logic  [31:0] prod_hl;

    // Low 64 bits of the product from three 32x32 partials.
    assign prod_ll = {32'd0, s1.sa[31:0]} * {32'd0, s1.sb[31:0]};
    assign prod_lh = s1.sa[31:0] * s1.sb[63:32];
    assign prod_hl = s1.sa[63:32] * s1.sb[31:0];

    always_comb
    begin
        s2_next.is_mul = (s1.kind == KIND_MUL);
        s2_next.p_ll   = prod_ll;
        s2_next.p_lh   = prod_lh;
        s2_next.p_hl   = prod_hl;
        s2_next.mask   = low_mask(s1.w);
        s2_next.w      = s1.w;
        s2_next.st     = s1.st;
        unique case (s1.kind)
            KIND_ADD:    s2_next.val = s1.sa + s1.sb;
            KIND_SUB:    s2_next.val = s1.sa - s1.sb;
            KIND_SHL:    s2_next.val = s1.a_m << s1.amount;
            KIND_SHR:    s2_next.val = s1.a_m >> s1.amount;
            KIND_RESIZE: s2_next.val = s1.sa;
            default:     s2_next.val = s1.a_m;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    assign out_valid = valid_reg;
    assign s2        = s2_reg;

endmodule

[src/vwfp_finish.sv]
module vwfp_finish
    import vwfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  s2_t  s2,
    output logic out_valid,
    output res_t res
);

    logic         valid_reg;
    res_t         res_reg;
    res_t         res_next;
    logic  [31:0] mid;
    logic  [63:0] raw;

    assign mid = s2.p_lh + s2.p_hl;
    assign raw = s2.is_mul ? (s2.p_ll + {mid, 32'd0}) : s2.val;

    always_comb
    begin
        res_next.result_width = s2.w;
        res_next.status       = s2.st;
        if (s2.st == ST_UNDER)
            res_next.result_value = '0;
        else
            res_next.result_value = raw & s2.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

[src/variable_width_fixed_point_alu.sv]
// An accepted transaction passes the decode, execute and finish registers in turn; done comes from finish.
// Throughput: one transaction per cycle, every cycle; busy is always low.
// The three register stages are decode, multiply/execute and combine/mask.
// Reset (rst_n low, asynchronous) clears only the stage valid bits; no results come out.
// The receiver cannot stall: each result sits on res for exactly one cycle with done.
module variable_width_fixed_point_alu
    import vwfp_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  op_t  op,
    output logic done,
    output res_t res
);

    // Stage 1 (decode): clamp operand widths, mask and sign-extend both
    // operands to 64 bits, work out the result width and status code.
    // Stage 2 (execute): add, subtract, shift, pass-through, and three
    // 32x32 partial products for multiply; build the result-width mask.
    // Stage 3 (finish): fold the partial products, pick the value, mask it
    // to the result width and zero it on underflow.
    //
    // No stage can hold, so the pipeline is always free to take a
    // transaction and busy is held low.

    logic accept;
    logic s1_valid;
    logic s2_valid;
    s1_t  s1;
    s2_t  s2;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    vwfp_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .op        (op),
        .out_valid (s1_valid),
        .s1        (s1)
    );

    vwfp_execute u_execute (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .s1        (s1),
        .out_valid (s2_valid),
        .s2        (s2)
    );

    vwfp_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .s2        (s2),
        .out_valid (done),
        .res       (res)
    );

endmodule

[src/vwfp_checker.sv]
`include "variable_width_fixed_point_alu_defines.svh"

module vwfp_checker
    import vwfp_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input op_t  op,
    input logic done,
    input res_t res
);

    `VWFP_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, 3, done)
    `VWFP_ASSERT_NOW(a_no_spurious, clk, rst_n, done, $past(start && !busy, 3))
    `VWFP_ASSERT_NOW(a_under_zero, clk, rst_n, done && res.status == ST_UNDER, res.result_value == '0 && res.result_width == WIDTH_W'(1))
    `VWFP_ASSERT_NOW(a_width_range, clk, rst_n, done, res.result_width != '0 && res.result_width <= WIDTH_W'(MAX_WIDTH) && (res.result_value & ~low_mask(res.result_width)) == '0)

endmodule

bind variable_width_fixed_point_alu vwfp_checker #(.MAX_WIDTH(MAX_WIDTH)) u_vwfp_checker (.*);
